@@ sv/aging_weighted_random_picker_unit_macros.svh @@
// Assertion macros for the aging weighted random picker.
`ifndef AGING_WEIGHTED_RANDOM_PICKER_UNIT_MACROS_SVH
`define AGING_WEIGHTED_RANDOM_PICKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define AWRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define AWRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/awrp_pkg.sv @@
// Shared types and constants for the aging weighted random picker.
`default_nettype none

package awrp_pkg;

    localparam int ENTRIES     = 32;
    localparam int RANDOM_BITS = 16;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int WGT_W   = 16;
    localparam int TOTAL_W = $clog2(ENTRIES * 32767 + 1);
    localparam int PROD_W  = RANDOM_BITS + TOTAL_W;

    typedef logic signed [WGT_W-1:0] t_weight;

    localparam t_weight WEIGHT_MAX = 16'sd32767;
    localparam t_weight ONE_UNIT   = 16'sd1;
    localparam t_weight PENALTY    = -t_weight'(ENTRIES / 2);

    localparam logic OP_PICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clear;        // all weights back to one unit
        logic start;        // latch fraction, zero total and index
        logic age_step;     // age one entry and add it to the total if positive
        logic mul;          // form the target, arm the search
        logic search_step;  // one step of the cumulative walk
        logic finish;       // penalize chosen entry, load output
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;     // index at last entry
        logic srch_last;    // index at last searched entry
        logic hit;          // running sum passes the target this step
        logic out_free;     // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

@@ sv/awrp_ctrl.sv @@
// Sequencer for the aging pass, target multiply and cumulative search.
`default_nettype none

module awrp_ctrl
    import awrp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_operation,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_MUL,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_AGE;
                    end
                end
            end
            S_AGE: begin
                o_cmd.age_step = 1'b1;
                if (i_sts.idx_last) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.hit || i_sts.srch_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ sv/awrp_datapath.sv @@
// Weight table, running sums, target multiply and output register.
`default_nettype none

module awrp_datapath
    import awrp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic [15:0]            i_random_fraction,
    input  wire logic                   i_stall,
    output t_sts                        o_sts,
    output logic                        o_valid,
    output logic [4:0]                  o_chosen_index
);

    t_weight                  r_weights [ENTRIES];
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_chosen;
    logic [RANDOM_BITS-1:0]   r_frac;
    logic [TOTAL_W-1:0]       r_total;
    logic [TOTAL_W-1:0]       r_running;
    logic [PROD_W-1:0]        r_target;
    logic                     r_out_valid;
    logic [4:0]               r_out_index;

    t_weight                  w_cur;
    t_weight                  w_aged;
    logic                     w_aged_pos;
    logic                     w_cur_pos;
    logic [TOTAL_W-1:0]       w_run_next;
    logic                     w_hit;

    assign w_cur      = r_weights[r_idx];
    assign w_aged     = (w_cur == WEIGHT_MAX) ? w_cur : w_cur + ONE_UNIT;
    assign w_aged_pos = !w_aged[WGT_W-1] && (w_aged != '0);
    assign w_cur_pos  = !w_cur[WGT_W-1] && (w_cur != '0);
    assign w_run_next = r_running + TOTAL_W'($unsigned(w_cur));
    // running * 2^RANDOM_BITS > fraction * total, exact
    assign w_hit      = w_cur_pos && ({w_run_next, {RANDOM_BITS{1'b0}}} > r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < ENTRIES; i++) r_weights[i] <= ONE_UNIT;
        end else if (i_cmd.age_step) begin
            r_weights[r_idx] <= w_aged;
        end else if (i_cmd.finish) begin
            r_weights[r_chosen] <= PENALTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start || i_cmd.mul) begin
                r_idx <= '0;
            end else if (i_cmd.age_step || i_cmd.search_step) begin
                r_idx <= o_sts.idx_last ? '0 : r_idx + IDX_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_frac  <= RANDOM_BITS'(i_random_fraction);
            r_total <= '0;
        end else if (i_cmd.age_step && w_aged_pos) begin
            r_total <= r_total + TOTAL_W'($unsigned(w_aged));
        end
        if (i_cmd.mul) begin
            r_target  <= PROD_W'(r_frac) * PROD_W'(r_total);
            r_running <= '0;
            r_chosen  <= IDX_W'(ENTRIES - 1);
        end else if (i_cmd.search_step && w_cur_pos) begin
            r_running <= w_run_next;
            if (w_hit) r_chosen <= r_idx;
        end
        if (i_cmd.finish) begin
            r_out_index <= 5'(r_chosen);
        end
    end

    assign o_sts.idx_last  = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.srch_last = (r_idx == IDX_W'(ENTRIES - 2));
    assign o_sts.hit       = w_hit;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_chosen_index = r_out_index;

endmodule

`default_nettype wire

@@ sv/aging_weighted_random_picker_unit.sv @@
// Roulette-wheel entry picker with aging: 32 signed weights, one pick or
// clear item at a time. A clear item resets all weights to one unit without
// making the block busy. A pick item walks the weight table twice through a
// single read port of the weight registers: an aging pass that also sums the
// positive weights, a multiply state for the fraction-times-total product, a
// cumulative search that ends at the first hit or at entry ENTRIES-2, and a
// finish state that writes the penalty and loads the output register; it
// waits there while the output register is held by o_valid with i_stall high.
// The block takes no new item until the pick is finished. The result stays
// in the output register while the next item is accepted. Weights come out
// of reset at one unit; there is no clearing sweep.
`default_nettype none
`include "aging_weighted_random_picker_unit_macros.svh"

module aging_weighted_random_picker_unit
    import awrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_random_fraction,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_chosen_index
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    awrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy)
    );

    awrp_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_random_fraction (i_random_fraction),
        .i_stall           (i_stall),
        .o_sts             (w_sts),
        .o_valid           (o_valid),
        .o_chosen_index    (o_chosen_index)
    );

    assign o_stall = w_busy;

    // a result is only loaded when the output register can take it
    `AWRP_ASSERT_NOW(a_finish_free, i_clk, i_rst_n, w_cmd.finish, w_sts.out_free, "finish while output held")
    // table walk steps only run while the input side is stalled
    `AWRP_ASSERT_NOW(a_step_busy, i_clk, i_rst_n, w_cmd.age_step || w_cmd.search_step, o_stall, "walk step while idle")
    // an accepted pick item keeps the block busy in the next cycle
    `AWRP_ASSERT_NEXT(a_pick_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_operation == OP_PICK), o_stall, "pick item did not start work")
    // a finished pick shows a valid result in the next cycle
    `AWRP_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, w_cmd.finish, o_valid && !o_stall, "finish did not load output")

endmodule

`default_nettype wire

@@ test/aging_weighted_random_picker_unit_test.sv @@
// Testbench for the aging weighted random picker: queued driver, checking monitor, predictor.
`default_nettype none

module aging_weighted_random_picker_unit_test;
    import awrp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
    localparam int HOLDOFF_AT   = 120;
    localparam int HOLDOFF_LEN  = 600;

    typedef struct packed {
        logic        op;
        logic [15:0] frac;
    } t_pick_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_operation = OP_PICK;
    logic [15:0] i_random_fraction = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [4:0]  o_chosen_index;

    aging_weighted_random_picker_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_random_fraction (i_random_fraction),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_chosen_index    (o_chosen_index)
    );

    t_pick_item       pending_items[$];
    t_pick_item       next_item;
    logic [IDX_W-1:0] expected_index_q[$];
    logic [IDX_W-1:0] want_index;
    t_weight          wheel_weights[ENTRIES];
    int               accepted_count = 0;
    int               total_items = 0;
    int               failures = 0;
    int               cycle_count = 0;
    int               holdoff_left = 0;
    logic             holdoff_done = 1'b0;
    logic             calm;

    // no idling on either side while this window of items goes through
    assign calm = (accepted_count >= 300) && (accepted_count < 400);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Clears, or ages, sums, searches and penalizes exactly as the block does.
    task automatic apply_item(input logic op, input logic [15:0] frac);
        logic [63:0] total;
        logic [63:0] running;
        logic [63:0] target;
        int          aged;
        int          chosen;
        if (op == OP_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) wheel_weights[i] = ONE_UNIT;
            return;
        end
        total = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            aged = int'(wheel_weights[i]) + 1;
            if (aged > int'(WEIGHT_MAX)) aged = int'(WEIGHT_MAX);
            wheel_weights[i] = t_weight'(aged);
            if (aged > 0) total += 64'(aged);
        end
        target  = 64'(frac) * total;
        running = '0;
        chosen  = ENTRIES - 1;
        for (int i = 0; i < ENTRIES - 1; i++) begin
            if (wheel_weights[i] > 0) begin
                running += 64'(int'(wheel_weights[i]));
                if ((running << RANDOM_BITS) > target) begin
                    chosen = i;
                    break;
                end
            end
        end
        wheel_weights[chosen] = PENALTY;
        expected_index_q.push_back(IDX_W'(chosen));
    endtask

    task automatic queue_item(input logic op, input logic [15:0] frac);
        pending_items.push_back(t_pick_item'{op: op, frac: frac});
        total_items++;
    endtask

    // Driver: holds an item until accepted, then maybe idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid           <= 1'b0;
            i_operation       <= OP_PICK;
            i_random_fraction <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_item(i_operation, i_random_fraction);
                accepted_count <= accepted_count + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                    next_item          = pending_items.pop_front();
                    i_valid           <= 1'b1;
                    i_operation       <= next_item.op;
                    i_random_fraction <= next_item.frac;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_stall      <= 1'b1;
        end else if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 29);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_index_q.size() == 0) begin
                $error("chosen_index: expected none, actual %0d", o_chosen_index);
                failures++;
            end else begin
                want_index = expected_index_q.pop_front();
                if (o_chosen_index !== want_index) begin
                    $error("chosen_index: expected %0d, actual %0d", want_index, o_chosen_index);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int          r;
        logic        op;
        logic [15:0] frac;

        for (int i = 0; i < ENTRIES; i++) wheel_weights[i] = ONE_UNIT;

        // directed: fraction extremes, both operations, runs that drive weights negative
        queue_item(OP_CLEAR, 16'h0000);
        queue_item(OP_PICK, 16'h0000);
        queue_item(OP_PICK, 16'hFFFF);
        queue_item(OP_PICK, 16'h8000);
        queue_item(OP_PICK, 16'h0001);
        queue_item(OP_PICK, 16'hFFFE);
        queue_item(OP_CLEAR, 16'hFFFF);
        for (int i = 0; i < 6; i++) queue_item(OP_PICK, 16'h0000);
        for (int i = 0; i < 4; i++) queue_item(OP_PICK, 16'hFFFF);
        queue_item(OP_PICK, 16'h7FFF);
        queue_item(OP_CLEAR, 16'h5A5A);
        queue_item(OP_PICK, 16'hFFFF);
        queue_item(OP_PICK, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            op = ($urandom_range(0, 99) < 8) ? OP_CLEAR : OP_PICK;
            r  = $urandom_range(0, 9);
            case (r)
                0: begin
                    frac = 16'h0000;
                end
                1: begin
                    frac = 16'hFFFF;
                end
                2: begin
                    frac = 16'($urandom_range(0, 255));
                end
                3: begin
                    frac = 16'hFF00 | 16'($urandom_range(0, 255));
                end
                default: begin
                    frac = 16'($urandom);
                end
            endcase
            queue_item(op, frac);
        end

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count != total_items) @(posedge i_clk);
        while (expected_index_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_index_q.size() != 0) begin
            $error("chosen_index: %0d results never arrived", expected_index_q.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/awrp_pkg.sv
sv/awrp_ctrl.sv
sv/awrp_datapath.sv
sv/aging_weighted_random_picker_unit.sv
test/aging_weighted_random_picker_unit_test.sv
